/* rtl/smlcg_pkg.sv */
package smlcg_pkg;

  localparam int InWidth  = 136;
  localparam int OutWidth = 112;
  localparam int StepW    = 18;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_DRAW = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;

  localparam logic [31:0] MULT_RESET = 32'd314159265;
  localparam logic [31:0] ADD_RESET  = 32'd178453311;
  localparam logic [31:0] ADD_BIAS   = 32'h10101010;

  typedef struct packed {
    logic start;
    logic mul;
    logic upd;
    logic scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic op_draw;
    logic out_busy;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

/* rtl/smlcg_ctrl.sv */
module smlcg_ctrl
  import smlcg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.steps_zero) begin
          state_nxt = status.op_draw ? ST_SCALE : ST_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/smlcg_dp.sv */
module smlcg_dp
  import smlcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [InWidth-1:0]  in_tdata,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutWidth-1:0] out_tdata
);

  logic [1:0]          opcode;
  logic [31:0]         seed_in, mult_in, addend_in;
  logic [14:0]         range_in;
  logic [15:0]         place_in;

  logic [31:0]         seed_r, mult_r, addend_r, prod_r;
  logic [StepW-1:0]    steps_r;
  logic                draw_r;
  logic [14:0]         range_r, value_r;
  logic                out_valid_r;
  logic [OutWidth-1:0] out_data_r;

  logic [31:0]         seed_new;
  logic [30:0]         scaled;

  assign opcode    = in_tdata[1:0];
  assign seed_in   = in_tdata[33:2];
  assign mult_in   = in_tdata[65:34];
  assign addend_in = in_tdata[97:66];
  assign range_in  = in_tdata[112:98];
  assign place_in  = in_tdata[128:113];

  assign seed_new = prod_r + addend_r;
  assign scaled   = {15'b0, seed_r[15:0]} * {16'b0, range_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      mult_r   <= MULT_RESET;
      addend_r <= ADD_RESET;
      steps_r  <= '0;
    end else if (cmd.start) begin
      if (opcode == OP_LOAD) begin
        seed_r   <= seed_in;
        mult_r   <= mult_in;
        addend_r <= addend_in;
      end
      case (opcode)
        OP_DRAW: steps_r <= StepW'(1);
        OP_SKIP: steps_r <= {place_in, 2'b00};
        default: steps_r <= '0;
      endcase
    end else if (cmd.upd) begin
      seed_r   <= seed_new;
      mult_r   <= (mult_r ^ seed_new) + 32'($signed(seed_new) >>> 4);
      addend_r <= addend_r + 32'($signed(seed_new) >>> 3) - ADD_BIAS;
      steps_r  <= steps_r - StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      draw_r  <= (opcode == OP_DRAW);
      range_r <= range_in;
      value_r <= '0;
    end else if (cmd.scale) begin
      value_r <= scaled[30:16];
    end
    if (cmd.mul) begin
      prod_r <= seed_r * mult_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, addend_r, mult_r, seed_r, value_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.steps_zero = (steps_r == '0);
  assign status.op_draw    = draw_r;
  assign status.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/self_modifying_lcg_random_unit.sv */
// Self-modifying LCG random generator.
// Input channel in_*: one item per operation (load, draw, skip; code 3 is a no-op).
// Result channel out_*: exactly one result item per input item, in order.
// One generator step is a 32x32 multiply into a register (ST_MUL),
// then the add and the multiplier/addend update (ST_UPD). A draw adds a
// scaling step (ST_SCALE) for the 16x15 multiply.
// Load and no-op skip the generator and go straight to the output; a draw
// runs a generator step, then the scaling; a skip runs the steps set by place_count.
// One item is in flight at a time; in_tready rises the cycle after the result
// is loaded into the output register, so a new item can be taken while that
// result still waits.
// If the receiver stalls, the finished result holds in the output register
// and the next item completes its work, then waits until the register frees.
// Reset: seed 0, multiplier 314159265, addend 178453311, no result pending.
module self_modifying_lcg_random_unit
  import smlcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // opcode[1:0], seed_in[33:2], mult_in[65:34], addend_in[97:66],
  // range_n[112:98], place_count[128:113], zero pad
  input  logic [InWidth-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // random_value[14:0], seed_out[46:15], mult_out[78:47], addend_out[110:79],
  // zero pad
  output logic [OutWidth-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;

  smlcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  smlcg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/smlcg_checker.sv */
module smlcg_checker
  import smlcg_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutWidth-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

endmodule

bind self_modifying_lcg_random_unit smlcg_checker u_smlcg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/self_modifying_lcg_random_unit_test.sv */
module self_modifying_lcg_random_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import smlcg_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_ITEMS = 80;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seed_in;
    logic [31:0] mult_in;
    logic [31:0] addend_in;
    logic [14:0] range_n;
    logic [15:0] place_count;
  } in_item_t;

  typedef struct packed {
    logic [14:0] random_value;
    logic [31:0] seed_out;
    logic [31:0] mult_out;
    logic [31:0] addend_out;
  } out_item_t;

  class lcg_scoreboard;
    logic [31:0] seed_w;
    logic [31:0] mult_w;
    logic [31:0] add_w;
    out_item_t   expected_q[$];
    int          errors;
    int          checked;
    int          n_load;
    int          n_draw;
    int          n_skip;
    int          n_none;
    longint      steps_run;

    function new();
      seed_w = '0;
      mult_w = MULT_RESET;
      add_w = ADD_RESET;
      errors = 0;
      checked = 0;
      n_load = 0;
      n_draw = 0;
      n_skip = 0;
      n_none = 0;
      steps_run = 0;
    endfunction

    function void advance();
      seed_w = seed_w * mult_w + add_w;
      mult_w = (mult_w ^ seed_w) + {{4{seed_w[31]}}, seed_w[31:4]};
      add_w = add_w + {{3{seed_w[31]}}, seed_w[31:3]} - ADD_BIAS;
      steps_run++;
    endfunction

    function void note_input(in_item_t it);
      out_item_t   res;
      logic [31:0] prod;
      logic [17:0] steps;
      res.random_value = '0;
      case (it.opcode)
        OP_LOAD: begin
          seed_w = it.seed_in;
          mult_w = it.mult_in;
          add_w = it.addend_in;
          n_load++;
        end
        OP_DRAW: begin
          advance();
          prod = {16'b0, seed_w[15:0]} * {17'b0, it.range_n};
          res.random_value = prod[30:16];
          n_draw++;
        end
        OP_SKIP: begin
          steps = {it.place_count, 2'b00};
          while (steps != 0) begin
            advance();
            steps--;
          end
          n_skip++;
        end
        default: n_none++;
      endcase
      res.seed_out = seed_w;
      res.mult_out = mult_w;
      res.addend_out = add_w;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OutWidth-1:0] data);
      out_item_t got;
      out_item_t want;
      got.random_value = data[14:0];
      got.seed_out = data[46:15];
      got.mult_out = data[78:47];
      got.addend_out = data[110:79];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, data);
      end else begin
        want = expected_q.pop_front();
        checked++;
        compare_field("random_value", {17'b0, want.random_value}, {17'b0, got.random_value});
        compare_field("seed_out", want.seed_out, got.seed_out);
        compare_field("mult_out", want.mult_out, got.mult_out);
        compare_field("addend_out", want.addend_out, got.addend_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [InWidth-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OutWidth-1:0] out_tdata;

  lcg_scoreboard sb = new();
  bit            idle_on = 1'b1;
  int            cycle_count = 0;

  self_modifying_lcg_random_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check on handshake, stall in bursts while idle_on is set
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] s, logic [31:0] m,
                                         logic [31:0] a, logic [14:0] r, logic [15:0] p);
    in_item_t it;
    it.opcode = op;
    it.seed_in = s;
    it.mult_in = m;
    it.addend_in = a;
    it.range_n = r;
    it.place_count = p;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = make_item(2'd0, $urandom, $urandom, $urandom, 15'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) it.opcode = OP_LOAD;
    else if (pick < 70) it.opcode = OP_DRAW;
    else if (pick < 95) it.opcode = OP_SKIP;
    else it.opcode = OP_NONE;
    pick = $urandom_range(0, 19);
    if (pick == 0) it.range_n = '1;
    else if (pick == 1) it.range_n = '0;
    pick = $urandom_range(0, 99);
    if (pick < 70) it.place_count = 16'($urandom_range(0, 7));
    else if (pick < 95) it.place_count = 16'($urandom_range(8, 63));
    else it.place_count = 16'($urandom_range(64, 255));
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, it.place_count, it.range_n, it.addend_in, it.mult_in, it.seed_in,
                 it.opcode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h7fff, 16'($urandom)));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h0000, 16'($urandom)));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h0001, 16'($urandom)));
    push_item(make_item(OP_LOAD, 32'h0, 32'h0, 32'h0, 15'h7fff, 16'hffff));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h5555, 16'hffff));
    push_item(make_item(OP_LOAD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 15'h0, 16'h0));
    push_item(make_item(OP_DRAW, 32'h0, 32'h0, 32'h0, 15'h2aaa, 16'h0));
    push_item(make_item(OP_LOAD, 32'h80000000, 32'h7fffffff, 32'h80000000, 15'($urandom),
                        16'($urandom)));
    push_item(make_item(OP_SKIP, $urandom, $urandom, $urandom, 15'($urandom), 16'h0000));
    push_item(make_item(OP_SKIP, $urandom, $urandom, $urandom, 15'($urandom), 16'h0001));
    push_item(make_item(OP_NONE, $urandom, $urandom, $urandom, 15'($urandom), 16'($urandom)));
    push_item(make_item(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 15'h7fff, 16'hffff));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h7fff, 16'($urandom)));
    push_item(make_item(OP_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 15'($urandom),
                        16'($urandom)));
    push_item(make_item(OP_SKIP, $urandom, $urandom, $urandom, 15'($urandom), 16'd3));
    push_item(make_item(OP_LOAD, 32'h0, MULT_RESET, ADD_RESET, 15'($urandom), 16'($urandom)));
    push_item(make_item(OP_SKIP, $urandom, $urandom, $urandom, 15'($urandom), 16'd2));
    push_item(make_item(OP_SKIP, $urandom, $urandom, $urandom, 15'($urandom), 16'hffff));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h7fff, 16'($urandom)));
    push_item(make_item(OP_DRAW, $urandom, $urandom, $urandom, 15'h4000, 16'($urandom)));

    // random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      push_item(random_item());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d loads, %0d draws, %0d skips (%0d steps), %0d unused-opcode items;",
             sb.n_load, sb.n_draw, sb.n_skip, sb.steps_run, sb.n_none);
    $display("%0d results compared, %0d errors, with random stalls on both sides.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
